// ----- hw/rtl/cbs_pkg.sv -----
// Shared types, constants and functions for the centered binomial sampler.
package cbs_pkg;

    // Coefficients per polynomial and the width of the position counter.
    localparam int POLY_LENGTH = 256;
    localparam int CNT_W       = $clog2(POLY_LENGTH);

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int COEFF_W = 4;
    localparam int INDEX_W = 8;

    // Bit gathering: at most eleven bits are ever held between bytes.
    localparam int BUF_W   = 11;
    localparam int BCNT_W  = 4;
    localparam int WORD_W  = 12;
    localparam int BITS_W  = BUF_W + BYTE_W;
    localparam int TOTAL_W = 5;

    // Group sizes for the two modes.
    localparam logic [TOTAL_W-1:0] GROUP_ETA6 = TOTAL_W'(12);
    localparam logic [TOTAL_W-1:0] GROUP_ETA5 = TOTAL_W'(10);

    // Mode register codes.
    localparam logic MODE_ETA6 = 1'b0;
    localparam logic MODE_ETA5 = 1'b1;

    // Depth of the queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One completed bit group on its way to the back end.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               eta5;
        logic [INDEX_W-1:0] index;
        logic               last;
    } cbs_item_t;

    // Number of set bits in a six-bit value.
    function automatic logic [2:0] popcount6(input logic [5:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 6; i++) begin
            n = n + 3'(v[i]);
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/cbs_front.sv -----
// Front end: gathers random bytes into bit groups and numbers the coefficients.
module cbs_front
    import cbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 eta_mode,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    in_byte,
    output logic                 push,
    output cbs_item_t            push_item,
    input  logic                 queue_full
);

    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [BCNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [CNT_W-1:0]   coeff_cnt_reg, coeff_cnt_next;

    logic [BITS_W-1:0]  bits;
    logic [BITS_W-1:0]  shifted;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] group;
    logic [TOTAL_W-1:0] remain;
    logic [31:0]        cnt_ext;
    logic               eta5;
    logic               group_done;
    logic               last;
    logic               accept;

    assign eta5       = (eta_mode == MODE_ETA5);
    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;

    // New byte sits directly above the bits already held.
    assign bits       = BITS_W'(buf_reg) | (BITS_W'(in_byte) << bcnt_reg);
    assign total      = TOTAL_W'(bcnt_reg) + TOTAL_W'(BYTE_W);
    assign group      = eta5 ? GROUP_ETA5 : GROUP_ETA6;
    assign group_done = (total >= group);
    assign remain     = total - group;
    assign shifted    = eta5 ? (bits >> 10) : (bits >> 12);

    assign cnt_ext    = 32'(coeff_cnt_reg);
    assign last       = (coeff_cnt_reg == CNT_W'(POLY_LENGTH - 1));

    assign push            = accept && group_done;
    assign push_item.word  = eta5 ? {2'b00, bits[9:0]} : bits[WORD_W-1:0];
    assign push_item.eta5  = eta5;
    assign push_item.index = cnt_ext[INDEX_W-1:0];
    assign push_item.last  = last;

    always_comb begin
        buf_next       = buf_reg;
        bcnt_next      = bcnt_reg;
        coeff_cnt_next = coeff_cnt_reg;
        if (accept) begin
            if (!group_done) begin
                buf_next  = bits[BUF_W-1:0];
                bcnt_next = total[BCNT_W-1:0];
            end else if (last) begin
                // Every polynomial starts on a byte boundary.
                buf_next       = '0;
                bcnt_next      = '0;
                coeff_cnt_next = '0;
            end else begin
                buf_next       = shifted[BUF_W-1:0];
                bcnt_next      = remain[BCNT_W-1:0];
                coeff_cnt_next = coeff_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg       <= '0;
            bcnt_reg      <= '0;
            coeff_cnt_reg <= '0;
        end else begin
            buf_reg       <= buf_next;
            bcnt_reg      <= bcnt_next;
            coeff_cnt_reg <= coeff_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_bcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= BCNT_W'(BUF_W))
        else $error("front holds more bits than the buffer can keep");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_item.last) |=> (bcnt_reg == '0 && coeff_cnt_reg == '0))
        else $error("bit buffer not cleared after last coefficient");
`endif

endmodule

// ----- hw/rtl/cbs_queue.sv -----
// Short register queue between the front end and the back end.
module cbs_queue
    import cbs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cbs_item_t push_item,
    output logic      full,
    output logic      pop_valid,
    input  logic      pop,
    output cbs_item_t pop_item
);

    cbs_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("queue read while empty");
`endif

endmodule

// ----- hw/rtl/cbs_back.sv -----
// Back end: popcount difference of each bit group into the output register.
module cbs_back
    import cbs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_valid,
    output logic                      item_pop,
    input  cbs_item_t                 item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COEFF_W-1:0] out_coefficient,
    output logic [INDEX_W-1:0]        out_index,
    output logic                      out_last
);

    logic                      valid_reg, valid_next;
    logic signed [COEFF_W-1:0] coeff_reg;
    logic [INDEX_W-1:0]        index_reg;
    logic                      last_reg;

    logic [5:0]         low_half;
    logic [5:0]         high_half;
    logic [COEFF_W-1:0] diff;

    assign item_pop = item_valid && (!valid_reg || out_ready);

    assign low_half  = item.eta5 ? {1'b0, item.word[4:0]} : item.word[5:0];
    assign high_half = item.eta5 ? {1'b0, item.word[9:5]} : item.word[11:6];
    assign diff      = COEFF_W'(popcount6(low_half)) - COEFF_W'(popcount6(high_half));

    always_comb begin
        valid_next = valid_reg;
        if (item_pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            coeff_reg <= signed'(diff);
            index_reg <= item.index;
            last_reg  <= item.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid       = valid_reg;
    assign out_coefficient = coeff_reg;
    assign out_index       = index_reg;
    assign out_last        = last_reg;

`ifndef ASSERT_OFF
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && last_reg) |-> (index_reg == INDEX_W'(POLY_LENGTH - 1)))
        else $error("last coefficient carries the wrong position");

    a_coeff_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (coeff_reg >= -4'sd6 && coeff_reg <= 4'sd6))
        else $error("coefficient outside the binomial range");
`endif

endmodule

// ----- hw/rtl/centered_binomial_sampler.sv -----
// Top level of the centered binomial sampler: front end, queue and back end.
// A byte that completes a bit group passes through the queue and the back-end output register to m_*.
// Throughput: one random byte per cycle; the front end stalls only when the queue is full.
// Each accepted byte yields at most one coefficient, so the back end keeps pace while m_ready is high.
// Reset (aresetn low at a clock edge) empties the queue, the output and the bit buffer,
// zeroes the coefficient counter and selects eta 6.
module centered_binomial_sampler
    import cbs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    // Mode register write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_eta_mode,

    // Random byte input, one byte a beat.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [BYTE_W-1:0]         s_random_byte,

    // Coefficient output, one coefficient a beat.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COEFF_W-1:0] m_coefficient,
    output logic [INDEX_W-1:0]        m_coeff_index,
    output logic                      m_last_coeff
);

    logic      eta_mode_reg;
    logic      push;
    logic      queue_full;
    logic      queue_valid;
    logic      queue_pop;
    cbs_item_t push_item;
    cbs_item_t queue_item;

    // The mode register is always ready. A change must be made only while the block
    // is idle; the block does not enforce this. The front end reads the current value
    // as each group completes; the mode then travels with the group to the back end.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_mode_reg <= MODE_ETA6;
        end else if (cfg_valid && cfg_ready) begin
            eta_mode_reg <= cfg_eta_mode;
        end
    end

    // The front end appends each byte above the held bits and, once a full
    // group of twelve or ten bits is present, hands it to the queue together
    // with its position in the polynomial and the last-coefficient flag.
    cbs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eta_mode   (eta_mode_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_random_byte),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // The queue decouples the two halves so that a stall on the output does
    // not stop bytes from being gathered until it has filled.
    cbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop_valid (queue_valid),
        .pop       (queue_pop),
        .pop_item  (queue_item)
    );

    // The back end forms the popcount difference and holds the result in the
    // output register until the downstream beat completes.
    cbs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (queue_valid),
        .item_pop        (queue_pop),
        .item            (queue_item),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_coefficient (m_coefficient),
        .out_index       (m_coeff_index),
        .out_last        (m_last_coeff)
    );

endmodule
